// ----- design/pts_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_pkg: shared types and constants of the periodic timer task scheduler
// Holds the table size, the field widths, the command and result codes and
// the packed item types of both channels.
// ----------------------------------------------------------------------------
package pts_pkg;

    // Table size and derived widths.
    localparam int SLOTS   = 16;
    localparam int IDX_W   = $clog2(SLOTS);
    localparam int MAX_OUT = 16;
    localparam int CNT_W   = $clog2(MAX_OUT + 1);

    // Field widths.
    localparam int TIME_W = 48;
    localparam int ID_W   = 32;
    localparam int PER_W  = 32;
    localparam int BW_W   = 16;
    localparam int DIV_CNT_W = $clog2(TIME_W + 1);

    // Reset value of the batch window register.
    localparam logic [BW_W-1:0] BW_RESET = 16'd100;

    // Input commands.
    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_CANCEL = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_CANCEL = 2'd1;
    localparam logic [1:0] KIND_FIRE   = 2'd2;

    // One input item.
    typedef struct packed {
        logic [1:0]       command;
        logic [ID_W-1:0]  delay;
        logic [PER_W-1:0] period;
        logic [ID_W-1:0]  cancel_id;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic [1:0]        kind;
        logic [ID_W-1:0]   task_id;
        logic [TIME_W-1:0] fire_time;
        logic              ok;
        logic              last;
    } out_item_t;

endpackage

// ----- design/pts_rem_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_rem_unit: iterative remainder unit
// Restoring division of a 48-bit dividend by a 32-bit divisor, one quotient
// bit per cycle. Only the remainder is kept; done pulses when it is ready.
// ----------------------------------------------------------------------------
module pts_rem_unit
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [pts_pkg::TIME_W-1:0] dividend,
    input  logic [pts_pkg::PER_W-1:0]  divisor,
    output logic                       done,
    output logic [pts_pkg::PER_W-1:0]  remainder
);

    logic [pts_pkg::PER_W-1:0]     rem_reg;
    logic [pts_pkg::TIME_W-1:0]    dvd_reg;
    logic [pts_pkg::PER_W-1:0]     dsr_reg;
    logic [pts_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;

    logic [pts_pkg::PER_W:0] trial;
    logic [pts_pkg::PER_W:0] diff;
    logic                    fits;

    // One restoring step: shift in the next dividend bit and subtract if it fits.
    always_comb
    begin
        trial = {rem_reg, dvd_reg[pts_pkg::TIME_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        fits  = (trial >= {1'b0, dsr_reg});
    end

    // Control of the iteration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == pts_pkg::DIV_CNT_W'(pts_pkg::TIME_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath of the iteration.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[pts_pkg::PER_W-1:0] : trial[pts_pkg::PER_W-1:0];
            dvd_reg <= {dvd_reg[pts_pkg::TIME_W-2:0], 1'b0};
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ----- design/periodic_timer_task_scheduler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_timer_task_scheduler: table of one-shot and periodic timer tasks
// An add item stores a task, a cancel item deactivates one, and a tick item
// advances time and fires the due tasks in trigger order.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one command item per handshake (in_valid, in_stall,
// in_item). The block takes one item at a time: in_stall stays high until all
// results of the current item have been handed to the output register.
// The output channel (out_valid, out_stall, out_item) is a register, so the
// next item can be taken while the final result still waits downstream; the
// final result of each item carries last.
// Per item: an add needs no scan; a cancel scans every slot; a tick scans every
// slot and, when something is due, runs for every taken task one selection scan
// over the slots and one handling step, one more selection scan that finds
// nothing left, and the shared remainder unit when a periodic task has to skip
// missed periods. The slot scans go one entry per cycle and the remainder unit
// is bit-serial. When the receiver stalls, the sequencer waits with its next
// fired task until the output register frees up. Reset clears time to zero,
// the next id to one, frees every slot and sets the batch window to 100.
// cfg_we writes the batch window; the user must assert it only while the block
// is idle, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module periodic_timer_task_scheduler
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  pts_pkg::in_item_t        in_item,
    output logic                     out_valid,
    input  logic                     out_stall,
    output pts_pkg::out_item_t       out_item,
    input  logic                     cfg_we,
    input  logic [pts_pkg::BW_W-1:0] cfg_wdata
);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CSCAN = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_PICK  = 3'd3;
    localparam logic [2:0] S_PROC  = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_FLUSH = 3'd6;

    localparam logic [pts_pkg::IDX_W-1:0] LAST_IDX = pts_pkg::IDX_W'(pts_pkg::SLOTS - 1);

    // Control registers.
    logic [2:0]                   state_reg, state_next;
    logic [pts_pkg::IDX_W-1:0]    idx_reg, idx_next;
    logic [pts_pkg::TIME_W-1:0]   now_reg, now_next;
    logic [pts_pkg::ID_W-1:0]     next_id_reg, next_id_next;
    logic [pts_pkg::BW_W-1:0]     bw_reg, bw_next;
    logic [pts_pkg::SLOTS-1:0]    used_reg;
    logic [pts_pkg::SLOTS-1:0]    taken_reg;
    logic                         found_reg, found_next;
    logic                         any_reg, any_next;
    logic                         bvalid_reg, bvalid_next;
    logic [pts_pkg::CNT_W-1:0]    fcnt_reg, fcnt_next;
    logic                         hold_valid_reg, hold_valid_next;
    logic                         out_valid_reg, out_valid_next;

    // Payload registers.
    logic [pts_pkg::SLOTS-1:0]    live_reg;
    logic [pts_pkg::TIME_W-1:0]   due_reg   [pts_pkg::SLOTS];
    logic [pts_pkg::PER_W-1:0]    per_reg   [pts_pkg::SLOTS];
    logic [pts_pkg::ID_W-1:0]     ident_reg [pts_pkg::SLOTS];
    logic [pts_pkg::ID_W-1:0]     cid_reg, cid_next;
    logic [pts_pkg::TIME_W-1:0]   earliest_reg, earliest_next;
    logic [pts_pkg::IDX_W-1:0]    best_reg, best_next;
    logic [pts_pkg::TIME_W-1:0]   bdue_reg, bdue_next;
    pts_pkg::out_item_t           hold_reg, hold_next;
    pts_pkg::out_item_t           out_reg, out_next;

    // Slot read port and helpers.
    logic [pts_pkg::IDX_W-1:0]    rd_idx;
    logic [pts_pkg::TIME_W-1:0]   rd_due;
    logic [pts_pkg::PER_W-1:0]    rd_per;
    logic [pts_pkg::ID_W-1:0]     rd_ident;
    logic                         rd_used;
    logic                         rd_live;
    logic [pts_pkg::TIME_W:0]     bend;
    logic                         out_free;
    logic                         in_accept;
    logic [pts_pkg::IDX_W-1:0]    free_idx;
    logic                         free_any;
    logic [pts_pkg::TIME_W-1:0]   add_due;
    logic [pts_pkg::ID_W-1:0]     id_inc;

    // Write strobes for the slot table.
    logic                         add_we;
    logic                         due_we;
    logic [pts_pkg::TIME_W-1:0]   due_wdata;
    logic                         used_clr;
    logic                         live_clr;
    logic                         taken_we;
    logic                         taken_val;
    logic                         taken_clr;
    logic                         emit;
    pts_pkg::out_item_t           emit_item;

    // Scan temporaries.
    logic                         hit;
    logic                         found_n;
    logic                         upd;
    logic                         any_n;
    logic [pts_pkg::TIME_W-1:0]   earl_n;
    logic                         cand;
    logic                         bv_n;
    logic                         fire_now;

    // Remainder unit.
    logic                         div_start;
    logic                         div_done;
    logic [pts_pkg::PER_W-1:0]    div_rem;

    pts_rem_unit u_rem
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (now_reg - rd_due),
        .divisor   (rd_per),
        .done      (div_done),
        .remainder (div_rem)
    );

    // Shared read port: the scan index, or the chosen slot while it is handled.
    assign rd_idx   = (state_reg == S_PROC || state_reg == S_DIV) ? best_reg : idx_reg;
    assign rd_due   = due_reg[rd_idx];
    assign rd_per   = per_reg[rd_idx];
    assign rd_ident = ident_reg[rd_idx];
    assign rd_used  = used_reg[rd_idx];
    assign rd_live  = live_reg[rd_idx];

    assign bend      = {1'b0, now_reg} + {{(pts_pkg::TIME_W + 1 - pts_pkg::BW_W){1'b0}}, bw_reg};
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign add_due   = now_reg + {{(pts_pkg::TIME_W - pts_pkg::ID_W){1'b0}}, in_item.delay};
    assign id_inc    = next_id_reg + 1'b1;

    // Lowest free slot.
    always_comb
    begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = pts_pkg::SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_idx = pts_pkg::IDX_W'(i);
                free_any = 1'b1;
            end
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        now_next        = now_reg;
        next_id_next    = next_id_reg;
        bw_next         = bw_reg;
        found_next      = found_reg;
        any_next        = any_reg;
        bvalid_next     = bvalid_reg;
        fcnt_next       = fcnt_reg;
        cid_next        = cid_reg;
        earliest_next   = earliest_reg;
        best_next       = best_reg;
        bdue_next       = bdue_reg;
        add_we          = 1'b0;
        due_we          = 1'b0;
        due_wdata       = rd_due;
        used_clr        = 1'b0;
        live_clr        = 1'b0;
        taken_we        = 1'b0;
        taken_val       = 1'b0;
        taken_clr       = 1'b0;
        emit            = 1'b0;
        emit_item       = '0;
        div_start       = 1'b0;
        hit             = rd_used && (rd_ident == cid_reg);
        found_n         = found_reg || hit;
        upd             = rd_used && (!any_reg || rd_due < earliest_reg);
        any_n           = any_reg || rd_used;
        earl_n          = upd ? rd_due : earliest_reg;
        cand            = taken_reg[idx_reg] && (!bvalid_reg || rd_due < bdue_reg);
        bv_n            = bvalid_reg || cand;
        fire_now        = rd_live && (fcnt_reg < pts_pkg::CNT_W'(pts_pkg::MAX_OUT));

        if (cfg_we)
        begin
            bw_next = cfg_wdata;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    priority case (in_item.command)
                        pts_pkg::CMD_ADD:
                        begin
                            emit = 1'b1;
                            if (free_any)
                            begin
                                add_we    = 1'b1;
                                emit_item = '{pts_pkg::KIND_ADD, next_id_reg, add_due,
                                              1'b1, 1'b0};
                                next_id_next = (id_inc == '0) ? pts_pkg::ID_W'(1) : id_inc;
                            end
                            else
                            begin
                                emit_item = '{pts_pkg::KIND_ADD, '0, '0, 1'b0, 1'b0};
                            end
                            state_next = S_FLUSH;
                        end
                        pts_pkg::CMD_CANCEL:
                        begin
                            cid_next   = in_item.cancel_id;
                            found_next = 1'b0;
                            idx_next   = '0;
                            state_next = S_CSCAN;
                        end
                        pts_pkg::CMD_TICK:
                        begin
                            now_next   = now_reg + 1'b1;
                            idx_next   = '0;
                            any_next   = 1'b0;
                            fcnt_next  = '0;
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Cancel: deactivate every stored task with the id.
            S_CSCAN:
            begin
                live_clr   = hit;
                found_next = found_n;
                if (idx_reg == LAST_IDX)
                begin
                    emit       = 1'b1;
                    emit_item  = '{pts_pkg::KIND_CANCEL, cid_reg, '0, found_n, 1'b0};
                    state_next = S_FLUSH;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            // Tick: find the earliest trigger and mark the batch in one pass.
            S_SCAN:
            begin
                taken_we      = 1'b1;
                taken_val     = rd_used && ({1'b0, rd_due} <= bend);
                any_next      = any_n;
                earliest_next = earl_n;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next    = '0;
                    bvalid_next = 1'b0;
                    if (!any_n || earl_n > now_reg)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        state_next = S_PICK;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            // Select the taken task with the earliest trigger, lower slot on ties.
            S_PICK:
            begin
                bvalid_next = bv_n;
                if (cand)
                begin
                    best_next = idx_reg;
                    bdue_next = rd_due;
                end
                if (idx_reg == LAST_IDX)
                begin
                    state_next = bv_n ? S_PROC : S_FLUSH;
                end
                idx_next = idx_reg + 1'b1;
            end

            // Report the chosen task if it is live and the per-tick limit is not reached, then reschedule or free it.
            S_PROC:
            begin
                if (!(fire_now && hold_valid_reg && !out_free))
                begin
                    taken_clr   = 1'b1;
                    idx_next    = '0;
                    bvalid_next = 1'b0;
                    state_next  = S_PICK;
                    if (fire_now)
                    begin
                        emit      = 1'b1;
                        emit_item = '{pts_pkg::KIND_FIRE, rd_ident, rd_due, 1'b1, 1'b0};
                        fcnt_next = fcnt_reg + 1'b1;
                    end
                    if (rd_live && rd_per != '0)
                    begin
                        if (rd_due <= now_reg)
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                        else
                        begin
                            due_we    = 1'b1;
                            due_wdata = rd_due + {{(pts_pkg::TIME_W - pts_pkg::PER_W){1'b0}},
                                                  rd_per};
                        end
                    end
                    else
                    begin
                        used_clr = 1'b1;
                    end
                end
            end

            // Next period after now: now - ((now - due) mod period) + period.
            S_DIV:
            begin
                if (div_done)
                begin
                    due_we     = 1'b1;
                    due_wdata  = now_reg
                               - {{(pts_pkg::TIME_W - pts_pkg::PER_W){1'b0}}, div_rem}
                               + {{(pts_pkg::TIME_W - pts_pkg::PER_W){1'b0}}, rd_per};
                    state_next = S_PICK;
                end
            end

            S_FLUSH:
            begin
                if (!hold_valid_reg || out_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result path: a one-item hold register in front of the output register,
    // so the final result can be marked last.
    always_comb
    begin
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && out_stall;
        if (emit)
        begin
            if (hold_valid_reg)
            begin
                out_next       = hold_reg;
                out_next.last  = 1'b0;
                out_valid_next = 1'b1;
            end
            hold_next       = emit_item;
            hold_valid_next = 1'b1;
        end
        else if (state_reg == S_FLUSH && hold_valid_reg && out_free)
        begin
            out_next        = hold_reg;
            out_next.last   = 1'b1;
            out_valid_next  = 1'b1;
            hold_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            now_reg        <= '0;
            next_id_reg    <= pts_pkg::ID_W'(1);
            bw_reg         <= pts_pkg::BW_RESET;
            used_reg       <= '0;
            taken_reg      <= '0;
            found_reg      <= 1'b0;
            any_reg        <= 1'b0;
            bvalid_reg     <= 1'b0;
            fcnt_reg       <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            now_reg        <= now_next;
            next_id_reg    <= next_id_next;
            bw_reg         <= bw_next;
            found_reg      <= found_next;
            any_reg        <= any_next;
            bvalid_reg     <= bvalid_next;
            fcnt_reg       <= fcnt_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            if (add_we)
            begin
                used_reg[free_idx] <= 1'b1;
            end
            if (used_clr)
            begin
                used_reg[best_reg] <= 1'b0;
            end
            if (taken_we)
            begin
                taken_reg[idx_reg] <= taken_val;
            end
            if (taken_clr)
            begin
                taken_reg[best_reg] <= 1'b0;
            end
        end
    end

    // Slot table and payload.
    always_ff @(posedge clk)
    begin
        cid_reg      <= cid_next;
        earliest_reg <= earliest_next;
        best_reg     <= best_next;
        bdue_reg     <= bdue_next;
        hold_reg     <= hold_next;
        out_reg      <= out_next;
        if (add_we)
        begin
            live_reg[free_idx]  <= 1'b1;
            due_reg[free_idx]   <= add_due;
            per_reg[free_idx]   <= in_item.period;
            ident_reg[free_idx] <= next_id_reg;
        end
        if (live_clr)
        begin
            live_reg[idx_reg] <= 1'b0;
        end
        if (due_we)
        begin
            due_reg[best_reg] <= due_wdata;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // The hold register is always drained before the block takes a new item.
    a_hold_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !hold_valid_reg)
        else $error("result left in hold register while idle");

    // The remainder unit only reports while the sequencer waits for it.
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("remainder ready outside of the division state");

    // Add and cancel replies are always the single, final result of their item.
    a_reply_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.kind != pts_pkg::KIND_FIRE) |-> out_reg.last)
        else $error("add or cancel reply not marked last");

    // No more fired results than allowed per tick.
    a_fire_count: assert property (@(posedge clk) disable iff (!rst_n)
        fcnt_reg <= pts_pkg::CNT_W'(pts_pkg::MAX_OUT))
        else $error("too many fired results in one tick");

endmodule

// ----- sim/tb_periodic_timer_task_scheduler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_periodic_timer_task_scheduler: self-checking bench of the task scheduler
// Sends add, cancel and tick items, predicts every add reply, cancel reply
// and fired task, and compares each result field by field.
// It also goes through several batch window settings, with random idling on
// both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_periodic_timer_task_scheduler;
    import pts_pkg::*;

    localparam int  CYCLE_LIMIT  = 2000000;
    localparam int  SETTLE_CYCLES = 1500;
    localparam int  HOLD_CYCLES  = 2000;

    // Timer table predictor and store of expected results.
    class sched_scoreboard;
        logic [TIME_W-1:0] now_t;
        logic [ID_W-1:0]   id_next;
        logic [BW_W-1:0]   window;
        bit                used [SLOTS];
        bit                live [SLOTS];
        logic [TIME_W-1:0] due_t [SLOTS];
        logic [PER_W-1:0]  per_t [SLOTS];
        logic [ID_W-1:0]   ident [SLOTS];
        out_item_t         expected_q [$];
        int                errors;

        function new();
            now_t   = '0;
            id_next = 1;
            window  = BW_RESET;
            errors  = 0;
            foreach (used[i])
            begin
                used[i] = 0;
                live[i] = 0;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // First time due + k * period, k >= 1, that lies after now.
        function logic [TIME_W-1:0] next_trigger(logic [TIME_W-1:0] d,
                                                 logic [PER_W-1:0] p);
            longint unsigned k;
            k = 1;
            if (d <= now_t)
                k = (longint'(now_t) - longint'(d)) / longint'(p) + 1;
            return TIME_W'(longint'(d) + k * longint'(p));
        endfunction

        // Work out the results of one accepted input item.
        function void note_input(in_item_t it);
            out_item_t r;
            out_item_t res_q [$];
            bit taken [SLOTS];
            bit any;
            bit found;
            logic [TIME_W-1:0] earliest;
            longint unsigned bend;
            int slot;
            int best;
            slot = -1;
            any = 0;
            found = 0;
            earliest = '0;
            r = '0;
            case (it.command)
                CMD_ADD:
                begin
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (!used[i])
                            slot = i;
                    r.kind = KIND_ADD;
                    if (slot >= 0)
                    begin
                        used[slot]  = 1;
                        live[slot]  = 1;
                        due_t[slot] = now_t + TIME_W'(it.delay);
                        per_t[slot] = it.period;
                        ident[slot] = id_next;
                        r.task_id   = id_next;
                        r.fire_time = due_t[slot];
                        r.ok        = 1'b1;
                        id_next = id_next + 1;
                        if (id_next == 0)
                            id_next = 1;
                    end
                    res_q = {res_q, r};
                end
                CMD_CANCEL:
                begin
                    for (int i = 0; i < SLOTS; i++)
                        if (used[i] && ident[i] == it.cancel_id)
                        begin
                            live[i] = 0;
                            found = 1;
                        end
                    r.kind    = KIND_CANCEL;
                    r.task_id = it.cancel_id;
                    r.ok      = found;
                    res_q = {res_q, r};
                end
                CMD_TICK:
                begin
                    now_t = now_t + 1;
                    for (int i = 0; i < SLOTS; i++)
                        if (used[i] && (!any || due_t[i] < earliest))
                        begin
                            earliest = due_t[i];
                            any = 1;
                        end
                    if (any && earliest <= now_t)
                    begin
                        // The batch end is compared without wrapping.
                        bend = longint'(now_t) + longint'(window);
                        for (int i = 0; i < SLOTS; i++)
                            taken[i] = used[i] && (longint'(due_t[i]) <= bend);
                        forever
                        begin
                            best = -1;
                            for (int i = 0; i < SLOTS; i++)
                                if (taken[i] && (best < 0 || due_t[i] < due_t[best]))
                                    best = i;
                            if (best < 0)
                                break;
                            taken[best] = 0;
                            if (live[best])
                            begin
                                if (res_q.size() < MAX_OUT)
                                begin
                                    r = '0;
                                    r.kind      = KIND_FIRE;
                                    r.task_id   = ident[best];
                                    r.fire_time = due_t[best];
                                    r.ok        = 1'b1;
                                    res_q = {res_q, r};
                                end
                                if (per_t[best] != 0)
                                begin
                                    due_t[best] = next_trigger(due_t[best], per_t[best]);
                                    continue;
                                end
                            end
                            used[best] = 0;
                        end
                    end
                end
                default:
                begin
                    // Unused command: nothing happens.
                end
            endcase
            if (res_q.size() > 0)
                res_q[res_q.size() - 1].last = 1'b1;
            foreach (res_q[i])
                expected_q = {expected_q, res_q[i]};
        endfunction

        function void report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endfunction

        // Compare one accepted result with the oldest expectation.
        function void check(out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected result kind %0d id %0d", got.kind, got.task_id));
                return;
            end
            want = expected_q.pop_front();
            if (got.kind !== want.kind)
                report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
            if (got.task_id !== want.task_id)
                report($sformatf("task_id %0d, expected %0d", got.task_id, want.task_id));
            if (got.fire_time !== want.fire_time)
                report($sformatf("fire_time %0d, expected %0d", got.fire_time,
                                 want.fire_time));
            if (got.ok !== want.ok)
                report($sformatf("ok %0b, expected %0b", got.ok, want.ok));
            if (got.last !== want.last)
                report($sformatf("last %0b, expected %0b", got.last, want.last));
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_item;
    logic      cfg_we;
    logic [BW_W-1:0] cfg_wdata;

    sched_scoreboard sb;
    bit quiet;
    bit sender_idles;
    bit hold_req;
    bit hold_done;
    int cycles;

    periodic_timer_task_scheduler u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Clock with a 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Cycle counter that ends a hung run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check(out_item);
    end

    // Receiver: random stall bursts, one long hold-off on request.
    initial
    begin
        hold_done = 0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // Offer one item and wait until it is accepted.
    task automatic send_item(in_item_t it);
        if (sender_idles && !quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(it);
    endtask

    task automatic send_cmd(logic [1:0] c, logic [ID_W-1:0] d, logic [PER_W-1:0] p,
                            logic [ID_W-1:0] cid);
        in_item_t it;
        it.command   = c;
        it.delay     = d;
        it.period    = p;
        it.cancel_id = cid;
        send_item(it);
    endtask

    // Drain all results, let the block settle, then write the batch window.
    task automatic write_window(logic [BW_W-1:0] value);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.window = value;
    endtask

    // Random item, mostly well-formed traffic with small times.
    function automatic in_item_t random_item();
        in_item_t it;
        int pick;
        it.command   = 2'($urandom_range(0, 3));
        it.delay     = $urandom;
        it.period    = $urandom;
        it.cancel_id = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            it.command = CMD_TICK;
        else if (pick < 72)
        begin
            it.command = CMD_ADD;
            if ($urandom_range(0, 99) >= 2)
                it.delay = $urandom_range(0, 40);
            pick = $urandom_range(0, 99);
            if (pick < 40)
                it.period = 0;
            else if (pick < 88)
                it.period = $urandom_range(1, 30);
        end
        else if (pick < 95)
        begin
            it.command = CMD_CANCEL;
            if ($urandom_range(0, 9) < 7)
                it.cancel_id = sb.id_next - ID_W'($urandom_range(1, 20));
        end
        else
            it.command = 2'd3;
        return it;
    endfunction

    // Main sequence.
    initial
    begin
        sb = new();
        quiet = 0;
        sender_idles = 1;
        hold_req = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the reset batch window.
        send_cmd(CMD_ADD, 0, 0, 0);
        send_cmd(CMD_ADD, '1, 0, 0);
        send_cmd(CMD_ADD, 3, 5, 0);
        send_cmd(CMD_ADD, 1, '1, 0);
        send_cmd(CMD_CANCEL, 0, 0, 3);
        send_cmd(CMD_CANCEL, '1, '1, 3);
        send_cmd(CMD_CANCEL, 0, 0, '1);
        send_cmd(2'd3, '1, '1, '1);
        send_cmd(CMD_TICK, 0, 0, 0);
        send_cmd(CMD_TICK, '1, '1, '1);
        send_cmd(CMD_TICK, 0, 0, 0);
        // Fill the table until an add is refused, then let the batch fire.
        for (int i = 0; i < 15; i++)
            send_cmd(CMD_ADD, 2, (i % 3 == 0) ? 4 : 0, 0);
        repeat (4) send_cmd(CMD_TICK, 0, 0, 0);

        // Random phases over several batch windows.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: write_window(BW_W'(0));
                1: write_window('1);
                2: write_window(BW_W'($urandom_range(1, 60)));
                default: write_window(BW_RESET);
            endcase
            if (ph == 3)
                quiet = 1;
            for (int n = 0; n < 96; n++)
            begin
                if (ph == 1 && n == 20)
                    hold_req = 1;
                send_item(random_item());
            end
        end
        in_valid <= 1'b0;

        // Drain and finish.
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
